// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

    typedef enum logic [1:0] {
        PS_RELEASED = 2'd0,
        PS_SHORT    = 2'd1,
        PS_LONG     = 2'd2
    } t_press_state;

    typedef enum logic {
        CMD_POLL  = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    localparam int unsigned PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_HOLD       = 2'd1,
        REG_REMAIN     = 2'd2,
        REG_ACTIVE_LOW = 2'd3
    } t_reg_idx;

    localparam logic [31:0] DEBOUNCE_RST   = 32'd50;
    localparam logic [31:0] HOLD_RST       = 32'd1000;
    localparam logic [31:0] REMAIN_RST     = 32'd500;
    localparam logic        ACTIVE_LOW_RST = 1'b1;

endpackage

// ===== hw/rtl/bpc_if.sv =====
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, output cmd, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input cmd, input pin_level, input now_ms, output ready);
endinterface

interface bpc_out_if;
    logic                  valid;
    logic                  ready;
    bpc_pkg::t_press_state press_state;
    logic                  debounced_pressed;

    modport source (output valid, output press_state, output debounced_pressed, input ready);
    modport sink   (input valid, input press_state, input debounced_pressed, output ready);
endinterface

// ===== hw/rtl/button_press_classifier_top.sv =====
// An accepted poll or clear item goes to the input register, its result to the result register.
// Throughput: one item per cycle unless o_out.ready stalls the output; the two registers
// decouple the two channels, and the state update is a single 32-bit subtract/compare pass.
// Reset (synchronous, active low): button taken as released, no timers running,
// configuration back to debounce 50 ms, hold 1000 ms, remain 500 ms, active low.
module button_press_classifier_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bpc_in_if.sink                       i_in,
    bpc_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // Configuration registers.
    logic [31:0] r_debounce_ms;
    logic [31:0] r_hold_ms;
    logic [31:0] r_remain_ms;
    logic        r_active_low;

    logic             cfg_wr;
    bpc_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = bpc_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= bpc_pkg::DEBOUNCE_RST;
            r_hold_ms     <= bpc_pkg::HOLD_RST;
            r_remain_ms   <= bpc_pkg::REMAIN_RST;
            r_active_low  <= bpc_pkg::ACTIVE_LOW_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bpc_pkg::REG_DEBOUNCE:   r_debounce_ms <= pwdata;
                bpc_pkg::REG_HOLD:       r_hold_ms     <= pwdata;
                bpc_pkg::REG_REMAIN:     r_remain_ms   <= pwdata;
                bpc_pkg::REG_ACTIVE_LOW: r_active_low  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            bpc_pkg::REG_DEBOUNCE:   prdata = r_debounce_ms;
            bpc_pkg::REG_HOLD:       prdata = r_hold_ms;
            bpc_pkg::REG_REMAIN:     prdata = r_remain_ms;
            bpc_pkg::REG_ACTIVE_LOW: prdata = {31'd0, r_active_low};
            default:                 prdata = 32'd0;
        endcase
    end

    // Input register.
    logic        r_s1_vld;
    logic        r_s1_cmd;
    logic        r_s1_pin;
    logic [31:0] r_s1_now;

    // Result register.
    logic                  r_out_vld;
    bpc_pkg::t_press_state r_out_state;
    logic                  r_out_pressed;

    logic advance;

    assign advance    = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_cmd <= i_in.cmd;
            r_s1_pin <= i_in.pin_level;
            r_s1_now <= i_in.now_ms;
        end
    end

    // Button state.
    logic                  r_level_now,     n_level_now;
    logic                  r_level_before,  n_level_before;
    logic                  r_hold_mark,     n_hold_mark;
    logic                  r_blanking,      n_blanking;
    logic [31:0]           r_press_start,   n_press_start;
    logic                  r_press_timing,  n_press_timing;
    logic [31:0]           r_report_start,  n_report_start;
    logic                  r_report_timing, n_report_timing;
    bpc_pkg::t_press_state r_reported,      n_reported;
    logic                  found;

    logic [31:0] press_age;
    logic [31:0] report_age;
    logic        past_debounce;
    logic        past_hold;
    logic        past_remain;

    assign press_age     = r_s1_now - r_press_start;
    assign report_age    = r_s1_now - r_report_start;
    assign past_debounce = press_age > r_debounce_ms;
    assign past_hold     = press_age > r_hold_ms;
    assign past_remain   = report_age > r_remain_ms;

    always_comb begin
        logic sample;
        logic level;
        logic report_set;

        n_level_now     = r_level_now;
        n_level_before  = r_level_before;
        n_hold_mark     = r_hold_mark;
        n_blanking      = r_blanking;
        n_press_start   = r_press_start;
        n_press_timing  = r_press_timing;
        n_report_start  = r_report_start;
        n_report_timing = r_report_timing;
        n_reported      = r_reported;
        found           = 1'b0;
        sample          = 1'b1;
        level           = (r_s1_pin ^ r_active_low);
        report_set      = 1'b0;

        if (bpc_pkg::t_cmd'(r_s1_cmd) == bpc_pkg::CMD_CLEAR) begin
            if (r_reported == bpc_pkg::PS_SHORT) begin
                n_reported      = bpc_pkg::PS_RELEASED;
                n_report_timing = 1'b0;
            end
        end else begin
            if (r_blanking) begin
                if (past_debounce) begin
                    n_blanking = 1'b0;
                end else begin
                    sample = 1'b0;
                end
            end

            if (sample) begin
                n_level_before = r_level_now;
                n_level_now    = level;
                if (level != r_level_now) begin
                    if (level) begin
                        n_press_start  = r_s1_now;
                        n_press_timing = 1'b1;
                        n_blanking     = 1'b1;
                        n_hold_mark    = 1'b0;
                    end else begin
                        n_press_timing = 1'b0;
                        n_blanking     = 1'b0;
                    end
                end else begin
                    if (r_press_timing && !r_hold_mark && past_hold) begin
                        n_hold_mark = 1'b1;
                    end
                    found = level;
                end
            end

            // A found press saw no edge, so the press start and timer are unchanged here.
            if (found && r_press_timing && past_hold) begin
                n_reported      = bpc_pkg::PS_LONG;
                n_report_start  = r_s1_now;
                n_report_timing = 1'b1;
                report_set      = 1'b1;
            end else if (!n_level_now && n_level_before) begin
                if (n_hold_mark) begin
                    n_hold_mark = 1'b0;
                end else begin
                    n_reported      = bpc_pkg::PS_SHORT;
                    n_report_start  = r_s1_now;
                    n_report_timing = 1'b1;
                    report_set      = 1'b1;
                end
            end

            // A report set by this poll has an age of zero and cannot expire yet.
            if (!report_set && r_report_timing && past_remain) begin
                n_reported      = bpc_pkg::PS_RELEASED;
                n_report_timing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_now     <= 1'b0;
            r_level_before  <= 1'b0;
            r_hold_mark     <= 1'b0;
            r_blanking      <= 1'b0;
            r_press_start   <= 32'd0;
            r_press_timing  <= 1'b0;
            r_report_start  <= 32'd0;
            r_report_timing <= 1'b0;
            r_reported      <= bpc_pkg::PS_RELEASED;
        end else if (advance) begin
            r_level_now     <= n_level_now;
            r_level_before  <= n_level_before;
            r_hold_mark     <= n_hold_mark;
            r_blanking      <= n_blanking;
            r_press_start   <= n_press_start;
            r_press_timing  <= n_press_timing;
            r_report_start  <= n_report_start;
            r_report_timing <= n_report_timing;
            r_reported      <= n_reported;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_state   <= n_reported;
            r_out_pressed <= found;
        end
    end

    assign o_out.valid             = r_out_vld;
    assign o_out.press_state       = r_out_state;
    assign o_out.debounced_pressed = r_out_pressed;

endmodule
